@@ src/paes_pkg.sv @@
// Shared constants, types and saturating helpers for the edge sampler.
`timescale 1ns / 1ps
package paes_pkg;

    localparam int MAX_NODES_DEF      = 1024;
    localparam int MAX_STEP_EDGES_DEF = 16;

    localparam int STR_W   = 32;
    localparam int TOT_W   = 42;
    localparam int PROB_W  = 17;
    localparam int RAND_W  = 16;
    localparam int NODE_W  = 11;
    localparam int SC_W    = 3;
    localparam int CFG_IW  = 3;
    localparam int CUM_W   = PROB_W + 2;

    localparam logic [SC_W-1:0] SC_LOAD    = 3'd0;
    localparam logic [SC_W-1:0] SC_NEW_OLD = 3'd1;
    localparam logic [SC_W-1:0] SC_OLD_OLD = 3'd2;
    localparam logic [SC_W-1:0] SC_OLD_NEW = 3'd3;
    localparam logic [SC_W-1:0] SC_NEW_NEW = 3'd4;
    localparam logic [SC_W-1:0] SC_SELF    = 3'd5;

    localparam logic [CFG_IW-1:0] CFG_P_NEW_OLD = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_P_OLD_OLD = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_P_OLD_NEW = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_P_NEW_NEW = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_OUT_OFF   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_IN_OFF    = 3'd5;

    localparam logic [STR_W-1:0] OFFSET_RST = 32'd256;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    function automatic logic [STR_W-1:0] sat_str(input logic [STR_W-1:0] a,
                                                 input logic [STR_W-1:0] b);
        logic [STR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_str = s[STR_W] ? {STR_W{1'b1}} : s[STR_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                                 input logic [STR_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + (TOT_W+1)'(b);
        sat_tot = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

@@ src/paes_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module paes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/paes_cell.sv @@
// One cell of the pending-edge stack: holds source, target and weight.
`timescale 1ns / 1ps
module paes_cell #(
    parameter int IW = 10
) (
    input  logic                       i_clk,
    input  paes_pkg::t_cell_ctl        i_ctl,
    input  logic [IW-1:0]              i_lo_src,
    input  logic [IW-1:0]              i_lo_tgt,
    input  logic [paes_pkg::STR_W-1:0] i_lo_w,
    input  logic [IW-1:0]              i_hi_src,
    input  logic [IW-1:0]              i_hi_tgt,
    input  logic [paes_pkg::STR_W-1:0] i_hi_w,
    output logic [IW-1:0]              o_src,
    output logic [IW-1:0]              o_tgt,
    output logic [paes_pkg::STR_W-1:0] o_w
);

    logic [IW-1:0]              r_src;
    logic [IW-1:0]              r_tgt;
    logic [paes_pkg::STR_W-1:0] r_w;

    // push takes from the lower neighbor, pop from the upper one
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_src <= i_lo_src;
            r_tgt <= i_lo_tgt;
            r_w   <= i_lo_w;
        end else if (i_ctl.pop) begin
            r_src <= i_hi_src;
            r_tgt <= i_hi_tgt;
            r_w   <= i_hi_w;
        end
    end

    assign o_src = r_src;
    assign o_tgt = r_tgt;
    assign o_w   = r_w;

endmodule

@@ src/preferential_attachment_edge_sampler_top.sv @@
// Top level of the preferential-attachment edge sampler.
//
//  channel  direction  handshake              payload
//  input    in         i_valid / o_stall      kind, strengths, rands, weight, last
//  output   out        o_valid / i_stall      scenario, source, target, overflow
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// After reset the strength RAMs are swept to zero, no items taken. A load, or an edge
// that samples no node (or is dropped), needs no scan; one that samples goes through
// multiply, sum, multiply, threshold and a scan of the counted nodes (one RAM read port
// per table). A step close writes back each pending edge. One item at a time; the result
// register holds while stalled and the next item is taken once the result is loaded.
`timescale 1ns / 1ps
module preferential_attachment_edge_sampler_top #(
    parameter int MAX_NODES      = paes_pkg::MAX_NODES_DEF,
    parameter int MAX_STEP_EDGES = paes_pkg::MAX_STEP_EDGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic [paes_pkg::STR_W-1:0]  i_node_out_strength,
    input  logic [paes_pkg::STR_W-1:0]  i_node_in_strength,
    input  logic [paes_pkg::RAND_W-1:0] i_scenario_rand,
    input  logic [paes_pkg::RAND_W-1:0] i_source_rand,
    input  logic [paes_pkg::RAND_W-1:0] i_target_rand,
    input  logic [paes_pkg::STR_W-1:0]  i_edge_weight,
    input  logic                        i_last_in_step,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [paes_pkg::SC_W-1:0]   o_scenario,
    output logic [paes_pkg::NODE_W-1:0] o_source_node,
    output logic [paes_pkg::NODE_W-1:0] o_target_node,
    output logic                        o_overflow,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [paes_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [paes_pkg::STR_W-1:0]  i_cfg_data
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int PW  = $clog2(MAX_STEP_EDGES + 1);
    localparam int SW  = ((32 + NW > paes_pkg::TOT_W) ? 32 + NW : paes_pkg::TOT_W) + 1;
    localparam int AW  = SW + 1;
    localparam int MW  = NW + paes_pkg::STR_W;
    localparam int SD  = paes_pkg::STR_W;
    localparam int RW  = paes_pkg::RAND_W;
    localparam int CW  = paes_pkg::CUM_W;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_MUL   = 11'b00000000100,
        ST_SUM   = 11'b00000001000,
        ST_MUL2  = 11'b00000010000,
        ST_THR   = 11'b00000100000,
        ST_SCAN  = 11'b00001000000,
        ST_PUSH  = 11'b00010000000,
        ST_FL_RD = 11'b00100000000,
        ST_FL_WR = 11'b01000000000,
        ST_RES   = 11'b10000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [paes_pkg::PROB_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [SD-1:0]               r_off_o, r_off_i;

    // network state
    logic [paes_pkg::TOT_W-1:0] r_tot;
    logic [NW-1:0]              r_nc, r_snc;
    logic [PW-1:0]              r_pcnt;
    logic [IW-1:0]              r_clr;

    // item registers
    logic [paes_pkg::SC_W-1:0] r_sc;
    logic                      r_ovf, r_last, r_scan_o, r_scan_i;
    logic [RW-1:0]             r_srnd, r_trnd;
    logic [SD-1:0]             r_w;
    logic [IW-1:0]             r_src, r_tgt;

    // sampling datapath
    logic [MW-1:0]  r_prod_o, r_prod_i;
    logic [SW-1:0]  r_s_o, r_s_i;
    logic [31:0]    r_plo_o, r_plo_i;
    logic [SW-1:0]  r_phi_o, r_phi_i;
    logic [AW-1:0]  r_thr_o, r_thr_i;
    logic [AW-1:0]  r_acc_o, r_acc_i;
    logic           r_fnd_o, r_fnd_i;
    logic [NW-1:0]  r_ra;
    logic           r_dv;
    logic [IW-1:0]  r_di;

    // output register
    logic                        r_ov;
    logic [paes_pkg::SC_W-1:0]   r_o_sc;
    logic [IW-1:0]               r_o_src, r_o_tgt;
    logic                        r_o_ovf;

    // RAM ports
    logic          w_we_o, w_we_i;
    logic [IW-1:0] w_wa_o, w_wa_i, w_ra_o, w_ra_i;
    logic [SD-1:0] w_wd_o, w_wd_i, w_rd_o, w_rd_i;

    // pending stack
    paes_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0] w_c_src [MAX_STEP_EDGES];
    logic [IW-1:0] w_c_tgt [MAX_STEP_EDGES];
    logic [SD-1:0] w_c_w   [MAX_STEP_EDGES];

    logic          w_acc_in, w_load_ok;
    logic [CW-1:0] w_c1, w_c2, w_c3, w_c4, w_u;
    logic [paes_pkg::SC_W-1:0] w_sc;
    logic [1:0]    w_need;
    logic          w_e_ovf;
    logic [NW:0]   w_nc_need;
    logic [MW-1:0] w_mo, w_mi;
    logic [SW-1:0] w_ho, w_hi;
    logic [31:0]   w_lo_o, w_lo_i;
    logic [AW-1:0] w_an_o, w_an_i;
    logic          w_res_ld;

    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc_in    = i_valid && (r_state == ST_IDLE);
    assign w_load_ok   = (r_nc < NW'(MAX_NODES));

    // scenario pick from cumulative thresholds
    always_comb begin
        w_c1 = CW'(r_p0);
        w_c2 = w_c1 + CW'(r_p1);
        w_c3 = w_c2 + CW'(r_p2);
        w_c4 = w_c3 + CW'(r_p3);
        w_u  = CW'(i_scenario_rand);
        if (w_u <= w_c1) begin
            w_sc = paes_pkg::SC_NEW_OLD;
        end else if (w_u <= w_c2) begin
            w_sc = paes_pkg::SC_OLD_OLD;
        end else if (w_u <= w_c3) begin
            w_sc = paes_pkg::SC_OLD_NEW;
        end else if (w_u <= w_c4) begin
            w_sc = paes_pkg::SC_NEW_NEW;
        end else begin
            w_sc = paes_pkg::SC_SELF;
        end
        case (w_sc)
            paes_pkg::SC_OLD_OLD: w_need = 2'd0;
            paes_pkg::SC_NEW_NEW: w_need = 2'd2;
            default:              w_need = 2'd1;
        endcase
        w_nc_need = (NW+1)'(r_nc) + (NW+1)'(w_need);
        w_e_ovf   = (w_nc_need > (NW+1)'(MAX_NODES)) || (r_pcnt >= PW'(MAX_STEP_EDGES));
    end

    assign w_mo   = r_snc * r_off_o;
    assign w_mi   = r_snc * r_off_i;
    assign w_ho   = r_srnd * r_s_o[SW-1:16];
    assign w_hi   = r_trnd * r_s_i[SW-1:16];
    assign w_lo_o = r_srnd * r_s_o[15:0];
    assign w_lo_i = r_trnd * r_s_i[15:0];
    assign w_an_o = r_acc_o + AW'(w_rd_o) + AW'(r_off_o);
    assign w_an_i = r_acc_i + AW'(w_rd_i) + AW'(r_off_i);
    assign w_res_ld = (r_state == ST_RES) && (!r_ov || !i_stall);

    // RAM port muxing
    always_comb begin
        w_we_o = 1'b0;
        w_we_i = 1'b0;
        w_wa_o = r_nc[IW-1:0];
        w_wa_i = r_nc[IW-1:0];
        w_wd_o = i_node_out_strength;
        w_wd_i = i_node_in_strength;
        w_ra_o = r_ra[IW-1:0];
        w_ra_i = r_ra[IW-1:0];
        w_ctl  = '0;
        case (r_state)
            ST_CLEAR: begin
                w_we_o = 1'b1;
                w_we_i = 1'b1;
                w_wa_o = r_clr;
                w_wa_i = r_clr;
                w_wd_o = '0;
                w_wd_i = '0;
            end
            ST_IDLE: begin
                w_we_o = w_acc_in && !i_kind && w_load_ok;
                w_we_i = w_acc_in && !i_kind && w_load_ok;
            end
            ST_PUSH: begin
                w_ctl.push = !r_ovf;
            end
            ST_FL_RD: begin
                w_ra_o = w_c_src[0];
                w_ra_i = w_c_tgt[0];
            end
            ST_FL_WR: begin
                w_we_o     = 1'b1;
                w_we_i     = 1'b1;
                w_wa_o     = w_c_src[0];
                w_wa_i     = w_c_tgt[0];
                w_wd_o     = paes_pkg::sat_str(w_rd_o, w_c_w[0]);
                w_wd_i     = paes_pkg::sat_str(w_rd_i, w_c_w[0]);
                w_ctl.pop  = 1'b1;
            end
            default: ;
        endcase
    end

    paes_ram #(.WIDTH(SD), .DEPTH(MAX_NODES)) u_out_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_o),
        .i_waddr(w_wa_o),
        .i_wdata(w_wd_o),
        .i_raddr(w_ra_o),
        .o_rdata(w_rd_o)
    );

    paes_ram #(.WIDTH(SD), .DEPTH(MAX_NODES)) u_in_ram (
        .i_clk  (i_clk),
        .i_we   (w_we_i),
        .i_waddr(w_wa_i),
        .i_wdata(w_wd_i),
        .i_raddr(w_ra_i),
        .o_rdata(w_rd_i)
    );

    genvar k;
    generate
        for (k = 0; k < MAX_STEP_EDGES; k++) begin : g_cell
            logic [IW-1:0] w_lo_src, w_lo_tgt, w_hi_src, w_hi_tgt;
            logic [SD-1:0] w_lo_w, w_hi_w;
            if (k == 0) begin : g_head
                assign w_lo_src = r_src;
                assign w_lo_tgt = r_tgt;
                assign w_lo_w   = r_w;
            end else begin : g_body
                assign w_lo_src = w_c_src[k-1];
                assign w_lo_tgt = w_c_tgt[k-1];
                assign w_lo_w   = w_c_w[k-1];
            end
            if (k == MAX_STEP_EDGES - 1) begin : g_top
                assign w_hi_src = '0;
                assign w_hi_tgt = '0;
                assign w_hi_w   = '0;
            end else begin : g_mid
                assign w_hi_src = w_c_src[k+1];
                assign w_hi_tgt = w_c_tgt[k+1];
                assign w_hi_w   = w_c_w[k+1];
            end
            paes_cell #(.IW(IW)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_lo_src(w_lo_src),
                .i_lo_tgt(w_lo_tgt),
                .i_lo_w  (w_lo_w),
                .i_hi_src(w_hi_src),
                .i_hi_tgt(w_hi_tgt),
                .i_hi_w  (w_hi_w),
                .o_src   (w_c_src[k]),
                .o_tgt   (w_c_tgt[k]),
                .o_w     (w_c_w[k])
            );
        end
    endgenerate

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0    <= '0;
            r_p1    <= '0;
            r_p2    <= '0;
            r_p3    <= '0;
            r_off_o <= paes_pkg::OFFSET_RST;
            r_off_i <= paes_pkg::OFFSET_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                paes_pkg::CFG_P_NEW_OLD: r_p0    <= i_cfg_data[paes_pkg::PROB_W-1:0];
                paes_pkg::CFG_P_OLD_OLD: r_p1    <= i_cfg_data[paes_pkg::PROB_W-1:0];
                paes_pkg::CFG_P_OLD_NEW: r_p2    <= i_cfg_data[paes_pkg::PROB_W-1:0];
                paes_pkg::CFG_P_NEW_NEW: r_p3    <= i_cfg_data[paes_pkg::PROB_W-1:0];
                paes_pkg::CFG_OUT_OFF:   r_off_o <= i_cfg_data;
                paes_pkg::CFG_IN_OFF:    r_off_i <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_tot   <= '0;
            r_nc    <= '0;
            r_snc   <= '0;
            r_pcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_res_ld) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(MAX_NODES - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_acc_in) begin
                        if (!i_kind) begin
                            r_state <= ST_RES;
                            if (w_load_ok) begin
                                r_tot <= paes_pkg::sat_tot(r_tot, i_node_out_strength);
                                r_nc  <= r_nc + 1'b1;
                                r_snc <= r_nc + 1'b1;
                            end
                        end else begin
                            if (!w_e_ovf) begin
                                r_nc <= NW'(w_nc_need);
                            end
                            if (!w_e_ovf && (w_sc == paes_pkg::SC_NEW_OLD ||
                                             w_sc == paes_pkg::SC_OLD_OLD ||
                                             w_sc == paes_pkg::SC_OLD_NEW)) begin
                                r_state <= ST_MUL;
                            end else begin
                                r_state <= ST_PUSH;
                            end
                        end
                    end
                end
                ST_MUL:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_MUL2;
                ST_MUL2: r_state <= ST_THR;
                ST_THR: begin
                    r_state <= (r_snc == '0) ? ST_PUSH : ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_dv && (NW'(r_di) == r_snc - 1'b1)) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!r_ovf) begin
                        r_pcnt <= r_pcnt + 1'b1;
                    end
                    r_state <= r_last ? ST_FL_RD : ST_RES;
                end
                ST_FL_RD: begin
                    if (r_pcnt == '0) begin
                        r_snc   <= r_nc;
                        r_state <= ST_RES;
                    end else begin
                        r_state <= ST_FL_WR;
                    end
                end
                ST_FL_WR: begin
                    r_tot   <= paes_pkg::sat_tot(r_tot, w_c_w[0]);
                    r_pcnt  <= r_pcnt - 1'b1;
                    r_state <= ST_FL_RD;
                end
                ST_RES: begin
                    if (w_res_ld) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    r_srnd <= i_source_rand;
                    r_trnd <= i_target_rand;
                    r_w    <= i_edge_weight;
                    r_last <= i_last_in_step;
                    r_src  <= r_nc[IW-1:0];
                    if (!i_kind) begin
                        r_sc     <= paes_pkg::SC_LOAD;
                        r_ovf    <= !w_load_ok;
                        r_tgt    <= '0;
                        r_scan_o <= 1'b0;
                        r_scan_i <= 1'b0;
                    end else begin
                        r_sc     <= w_sc;
                        r_ovf    <= w_e_ovf;
                        r_tgt    <= (w_sc == paes_pkg::SC_NEW_NEW) ?
                                    r_nc[IW-1:0] + 1'b1 : r_nc[IW-1:0];
                        r_scan_o <= (w_sc == paes_pkg::SC_OLD_OLD) ||
                                    (w_sc == paes_pkg::SC_OLD_NEW);
                        r_scan_i <= (w_sc == paes_pkg::SC_NEW_OLD) ||
                                    (w_sc == paes_pkg::SC_OLD_OLD);
                    end
                end
            end
            ST_MUL: begin
                r_prod_o <= w_mo;
                r_prod_i <= w_mi;
            end
            ST_SUM: begin
                r_s_o <= SW'(r_tot) + SW'(r_prod_o);
                r_s_i <= SW'(r_tot) + SW'(r_prod_i);
            end
            ST_MUL2: begin
                r_plo_o <= w_lo_o;
                r_plo_i <= w_lo_i;
                r_phi_o <= w_ho;
                r_phi_i <= w_hi;
            end
            ST_THR: begin
                // ceil(rand * S / 65536)
                r_thr_o <= AW'(r_phi_o) + AW'(r_plo_o[31:16]) + AW'(r_plo_o[15:0] != '0);
                r_thr_i <= AW'(r_phi_i) + AW'(r_plo_i[31:16]) + AW'(r_plo_i[15:0] != '0);
                r_acc_o <= '0;
                r_acc_i <= '0;
                r_fnd_o <= 1'b0;
                r_fnd_i <= 1'b0;
                r_ra    <= '0;
                r_dv    <= 1'b0;
                // no slot reached falls back to the last counted node
                if (r_scan_o) begin
                    r_src <= (r_snc == '0) ? '0 : IW'(r_snc - 1'b1);
                end
                if (r_scan_i) begin
                    r_tgt <= (r_snc == '0) ? '0 : IW'(r_snc - 1'b1);
                end
            end
            ST_SCAN: begin
                r_dv <= (r_ra < r_snc);
                r_di <= r_ra[IW-1:0];
                if (r_ra < r_snc) begin
                    r_ra <= r_ra + 1'b1;
                end
                if (r_dv) begin
                    r_acc_o <= w_an_o;
                    r_acc_i <= w_an_i;
                    if (r_scan_o && !r_fnd_o && (w_an_o >= r_thr_o)) begin
                        r_fnd_o <= 1'b1;
                        r_src   <= r_di;
                    end
                    if (r_scan_i && !r_fnd_i && (w_an_i >= r_thr_i)) begin
                        r_fnd_i <= 1'b1;
                        r_tgt   <= r_di;
                    end
                end
            end
            default: ;
        endcase
        if (w_res_ld) begin
            r_o_sc  <= r_sc;
            r_o_ovf <= r_ovf;
            r_o_src <= r_ovf ? '0 : r_src;
            r_o_tgt <= r_ovf ? '0 : r_tgt;
        end
    end

    assign o_valid       = r_ov;
    assign o_scenario    = r_o_sc;
    assign o_source_node = paes_pkg::NODE_W'(r_o_src);
    assign o_target_node = paes_pkg::NODE_W'(r_o_tgt);
    assign o_overflow    = r_o_ovf;

endmodule

@@ verif/paes_checker.sv @@
// Scoreboard for the edge sampler: tracks network state, predicts each result and compares.
`timescale 1ns / 1ps
module paes_checker
    import paes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall_in,
    input  logic                i_kind,
    input  logic [STR_W-1:0]    i_node_out_strength,
    input  logic [STR_W-1:0]    i_node_in_strength,
    input  logic [RAND_W-1:0]   i_scenario_rand,
    input  logic [RAND_W-1:0]   i_source_rand,
    input  logic [RAND_W-1:0]   i_target_rand,
    input  logic [STR_W-1:0]    i_edge_weight,
    input  logic                i_last_in_step,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [SC_W-1:0]     i_scenario,
    input  logic [NODE_W-1:0]   i_source_node,
    input  logic [NODE_W-1:0]   i_target_node,
    input  logic                i_overflow,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [STR_W-1:0]    i_cfg_data,
    output int                  o_fail_count,
    output int                  o_waiting
);

    localparam int NODES = MAX_NODES_DEF;
    localparam int STEP_EDGES = MAX_STEP_EDGES_DEF;
    localparam longint unsigned STR_SAT = 64'hFFFF_FFFF;
    localparam longint unsigned TOT_SAT = 64'h3FF_FFFF_FFFF;

    typedef struct packed {
        logic [SC_W-1:0]   scenario;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] tgt;
        logic              ovf;
    } edge_result_t;

    bit [PROB_W-1:0]   prob [4];
    longint unsigned   out_off, in_off;
    bit [STR_W-1:0]    out_str [NODES];
    bit [STR_W-1:0]    in_str [NODES];
    longint unsigned   total_str;
    int                node_cnt, step_nodes, pend_cnt;
    int                pend_src [STEP_EDGES];
    int                pend_tgt [STEP_EDGES];
    bit [STR_W-1:0]    pend_w [STEP_EDGES];
    edge_result_t      expected_q [$];

    function automatic bit [STR_W-1:0] add_sat32(bit [STR_W-1:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > STR_SAT) ? STR_SAT[STR_W-1:0] : s[STR_W-1:0];
    endfunction

    function automatic longint unsigned add_sat_total(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > TOT_SAT) ? TOT_SAT : s;
    endfunction

    // Linear roulette scan over the nodes counted at step start or loaded since.
    function automatic int spin_wheel(bit use_in, longint unsigned offs, longint unsigned rnd);
        longint unsigned span, part, thr, acc;
        int n;
        n = step_nodes;
        acc = 0;
        if (n == 0) return 0;
        span = total_str + longint'(n) * offs;
        part = rnd * (span & 64'hFFFF);
        thr = rnd * (span >> 16) + (part >> 16) + ((part & 64'hFFFF) != 0);
        for (int i = 0; i < n; i++) begin
            acc += (use_in ? longint'(in_str[i]) : longint'(out_str[i])) + offs;
            if (acc >= thr) return i;
        end
        return n - 1;
    endfunction

    function automatic void close_step();
        for (int k = 0; k < pend_cnt; k++) begin
            if (pend_src[k] < NODES) out_str[pend_src[k]] = add_sat32(out_str[pend_src[k]], pend_w[k]);
            if (pend_tgt[k] < NODES) in_str[pend_tgt[k]] = add_sat32(in_str[pend_tgt[k]], pend_w[k]);
            total_str = add_sat_total(total_str, pend_w[k]);
        end
        pend_cnt = 0;
        step_nodes = node_cnt;
    endfunction

    function automatic edge_result_t grow_network();
        edge_result_t r;
        longint unsigned u, c1, c2, c3, c4;
        int need, src, tgt;
        r = '0;
        src = 0;
        tgt = 0;
        if (i_kind == 1'b0) begin
            r.scenario = SC_LOAD;
            if (node_cnt >= NODES) begin
                r.ovf = 1'b1;
            end else begin
                out_str[node_cnt] = i_node_out_strength;
                in_str[node_cnt] = i_node_in_strength;
                total_str = add_sat_total(total_str, i_node_out_strength);
                r.src = NODE_W'(node_cnt);
                node_cnt++;
                step_nodes = node_cnt;
            end
            return r;
        end
        u = i_scenario_rand;
        c1 = prob[0];
        c2 = c1 + prob[1];
        c3 = c2 + prob[2];
        c4 = c3 + prob[3];
        if (u <= c1) r.scenario = SC_NEW_OLD;
        else if (u <= c2) r.scenario = SC_OLD_OLD;
        else if (u <= c3) r.scenario = SC_OLD_NEW;
        else if (u <= c4) r.scenario = SC_NEW_NEW;
        else r.scenario = SC_SELF;
        need = (r.scenario == SC_OLD_OLD) ? 0 : ((r.scenario == SC_NEW_NEW) ? 2 : 1);
        if (node_cnt + need > NODES || pend_cnt >= STEP_EDGES) begin
            r.ovf = 1'b1;
        end else begin
            case (r.scenario)
                SC_NEW_OLD: begin
                    src = node_cnt++;
                    tgt = spin_wheel(1'b1, in_off, i_target_rand);
                end
                SC_OLD_OLD: begin
                    src = spin_wheel(1'b0, out_off, i_source_rand);
                    tgt = spin_wheel(1'b1, in_off, i_target_rand);
                end
                SC_OLD_NEW: begin
                    src = spin_wheel(1'b0, out_off, i_source_rand);
                    tgt = node_cnt++;
                end
                SC_NEW_NEW: begin
                    src = node_cnt;
                    tgt = node_cnt + 1;
                    node_cnt += 2;
                end
                default: begin
                    src = node_cnt;
                    tgt = node_cnt;
                    node_cnt++;
                end
            endcase
            pend_src[pend_cnt] = src;
            pend_tgt[pend_cnt] = tgt;
            pend_w[pend_cnt] = i_edge_weight;
            pend_cnt++;
            r.src = NODE_W'(src);
            r.tgt = NODE_W'(tgt);
        end
        if (i_last_in_step) close_step();
        return r;
    endfunction

    always @(posedge i_clk) begin
        edge_result_t exp_r;
        if (!i_rst_n) begin
            foreach (prob[k]) prob[k] = '0;
            out_off = OFFSET_RST;
            in_off = OFFSET_RST;
            foreach (out_str[k]) begin
                out_str[k] = '0;
                in_str[k] = '0;
            end
            total_str = 0;
            node_cnt = 0;
            step_nodes = 0;
            pend_cnt = 0;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_P_NEW_OLD: prob[0] = i_cfg_data[PROB_W-1:0];
                    CFG_P_OLD_OLD: prob[1] = i_cfg_data[PROB_W-1:0];
                    CFG_P_OLD_NEW: prob[2] = i_cfg_data[PROB_W-1:0];
                    CFG_P_NEW_NEW: prob[3] = i_cfg_data[PROB_W-1:0];
                    CFG_OUT_OFF:   out_off = i_cfg_data;
                    CFG_IN_OFF:    in_off = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) expected_q.push_back(grow_network());
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result sc=%0d src=%0d tgt=%0d ovf=%0d", $time,
                             i_scenario, i_source_node, i_target_node, i_overflow);
                    o_fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.scenario !== i_scenario) begin
                        $display("%0t: scenario expected %0d got %0d", $time,
                                 exp_r.scenario, i_scenario);
                        o_fail_count++;
                    end
                    if (exp_r.src !== i_source_node) begin
                        $display("%0t: source_node expected %0d got %0d", $time,
                                 exp_r.src, i_source_node);
                        o_fail_count++;
                    end
                    if (exp_r.tgt !== i_target_node) begin
                        $display("%0t: target_node expected %0d got %0d", $time,
                                 exp_r.tgt, i_target_node);
                        o_fail_count++;
                    end
                    if (exp_r.ovf !== i_overflow) begin
                        $display("%0t: overflow expected %0d got %0d", $time,
                                 exp_r.ovf, i_overflow);
                        o_fail_count++;
                    end
                end
            end
        end
        o_waiting = expected_q.size();
    end

endmodule

@@ verif/testbench.sv @@
// Stimulus, idle patterns, watchdog and verdict for the edge sampler.
`timescale 1ns / 1ps
module testbench;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;

    logic                          i_clk, i_rst_n;
    logic                          i_valid, o_stall, i_kind, i_last_in_step;
    logic [paes_pkg::STR_W-1:0]    i_node_out_strength, i_node_in_strength, i_edge_weight;
    logic [paes_pkg::RAND_W-1:0]   i_scenario_rand, i_source_rand, i_target_rand;
    logic                          o_valid, i_stall, o_overflow;
    logic [paes_pkg::SC_W-1:0]     o_scenario;
    logic [paes_pkg::NODE_W-1:0]   o_source_node, o_target_node;
    logic                          i_cfg_valid, o_cfg_ready;
    logic [paes_pkg::CFG_IW-1:0]   i_cfg_index;
    logic [paes_pkg::STR_W-1:0]    i_cfg_data;

    int                            fail_count, waiting;
    int                            tx_idle_pct, rx_stall_pct;
    bit                            hold_req;
    int                            quiet_cycles;
    bit [paes_pkg::PROB_W-1:0]     prob_now [4];

    preferential_attachment_edge_sampler_top DUT (.*);

    paes_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_kind,
        .i_node_out_strength, .i_node_in_strength, .i_scenario_rand, .i_source_rand,
        .i_target_rand, .i_edge_weight, .i_last_in_step,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_scenario(o_scenario),
        .i_source_node(o_source_node), .i_target_node(o_target_node),
        .i_overflow(o_overflow), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_waiting(waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int held;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic bit [paes_pkg::STR_W-1:0] pick_strength();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 1024);
            1: return $urandom();
            2: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic bit [paes_pkg::RAND_W-1:0] pick_fraction();
        int cum;
        cum = prob_now[0];
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: cum = prob_now[0];
                1: cum = prob_now[0] + prob_now[1];
                2: cum = prob_now[0] + prob_now[1] + prob_now[2];
                default: cum = prob_now[0] + prob_now[1] + prob_now[2] + prob_now[3];
            endcase
            return paes_pkg::RAND_W'(cum + $urandom_range(0, 1));
        end
        return $urandom_range(0, 65535);
    endfunction

    // valid stays high after the accepting edge only until the next item or a wait
    task automatic send_item(bit kind, bit [paes_pkg::STR_W-1:0] out_s,
                             bit [paes_pkg::STR_W-1:0] in_s,
                             bit [paes_pkg::RAND_W-1:0] u, bit [paes_pkg::RAND_W-1:0] srnd,
                             bit [paes_pkg::RAND_W-1:0] trnd,
                             bit [paes_pkg::STR_W-1:0] w, bit last);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_node_out_strength <= out_s;
        i_node_in_strength <= in_s;
        i_scenario_rand <= u;
        i_source_rand <= srnd;
        i_target_rand <= trnd;
        i_edge_weight <= w;
        i_last_in_step <= last;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic send_load(bit [paes_pkg::STR_W-1:0] out_s,
                             bit [paes_pkg::STR_W-1:0] in_s);
        send_item(1'b0, out_s, in_s, $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom_range(0, 1));
    endtask

    task automatic send_edge(bit [paes_pkg::RAND_W-1:0] u, bit last);
        send_item(1'b1, $urandom(), $urandom(), u, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), pick_strength(), last);
    endtask

    task automatic drain();
        int pause;
        i_valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        for (pause = 0; pause < 40; pause++) @(negedge i_clk);
    endtask

    // valid is dropped by the next item sent
    task automatic write_reg(logic [paes_pkg::CFG_IW-1:0] idx,
                             bit [paes_pkg::STR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        if (idx <= paes_pkg::CFG_P_NEW_NEW) prob_now[idx] = data[paes_pkg::PROB_W-1:0];
    endtask

    task automatic configure(bit [paes_pkg::STR_W-1:0] a, bit [paes_pkg::STR_W-1:0] b,
                             bit [paes_pkg::STR_W-1:0] g, bit [paes_pkg::STR_W-1:0] x,
                             bit [paes_pkg::STR_W-1:0] doff,
                             bit [paes_pkg::STR_W-1:0] dinn);
        drain();
        write_reg(paes_pkg::CFG_P_NEW_OLD, a);
        write_reg(paes_pkg::CFG_P_OLD_OLD, b);
        write_reg(paes_pkg::CFG_P_OLD_NEW, g);
        write_reg(paes_pkg::CFG_P_NEW_NEW, x);
        write_reg(paes_pkg::CFG_OUT_OFF, doff);
        write_reg(paes_pkg::CFG_IN_OFF, dinn);
    endtask

    // Mostly well-formed steps (optional loads, then edges closed by a last flag);
    // steps longer than the pending buffer hit its overflow.
    task automatic grow_random(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_load(pick_strength(), pick_strength());
                    sent++;
                end
            end
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_load(pick_strength(), pick_strength());
                    sent++;
                end
                send_edge(pick_fraction(),
                          ($urandom_range(0, 15) == 0) ? 1'b1 : (k == len - 1));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_node_out_strength = '0;
        i_node_in_strength = '0;
        i_scenario_rand = '0;
        i_source_rand = '0;
        i_target_rand = '0;
        i_edge_weight = '0;
        i_last_in_step = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        hold_req = 1'b0;
        foreach (prob_now[k]) prob_now[k] = '0;
        tx_idle_pct = 6;
        rx_stall_pct = 88;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty network, extreme strengths, thresholds edges, pending overflow.
        send_item(1'b1, '0, '0, 16'd0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(1'b1, '1, '1, 16'hFFFF, 16'hFFFF, 16'd0, 32'd0, 1'b1);
        send_item(1'b0, '1, '1, '0, '0, '0, '0, 1'b1);
        send_item(1'b0, '0, '0, '1, '1, '1, '1, 1'b0);
        send_item(1'b1, '0, '0, 16'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        configure(32'd1000, 32'd30000, 32'd10000, 32'd10000, 32'd0, 32'hFFFF_FFFF);
        send_edge(16'd1000, 1'b0);
        send_edge(16'd1001, 1'b0);
        send_edge(16'd31000, 1'b0);
        send_edge(16'd31001, 1'b0);
        send_edge(16'd41000, 1'b0);
        send_edge(16'd41001, 1'b0);
        send_edge(16'd51000, 1'b0);
        send_edge(16'd51001, 1'b1);
        for (int k = 0; k < 18; k++) send_edge(16'd2000, k == 17);

        configure(32'h1FFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        write_reg(3'd6, $urandom());
        write_reg(3'd7, $urandom());
        grow_random(30);
        configure(32'd6000, 32'd50000, 32'd5000, 32'd2000, 32'd256, 32'd256);
        grow_random(90);

        tx_idle_pct = 88;
        rx_stall_pct = 6;
        configure(32'd0, 32'd65536, 32'd0, 32'd0, $urandom(), $urandom());
        grow_random(40);
        configure($urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom_range(0, 4096), $urandom_range(0, 4096));
        grow_random(80);

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        configure(32'd3000, 32'd55000, 32'd3000, 32'd3000, 32'd512, 32'd128);
        hold_req = 1'b1;
        grow_random(110);

        // Closing step with the widest source offset and a minimal target offset.
        configure(32'd10000, 32'd40000, 32'd5000, 32'd5000, 32'hFFFF_FFFF, 32'd1);
        for (int k = 0; k < 20; k++) send_edge(pick_fraction(), k == 19);

        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ preferential_attachment_edge_sampler_top.f @@
src/paes_pkg.sv
src/paes_ram.sv
src/paes_cell.sv
src/preferential_attachment_edge_sampler_top.sv
verif/paes_checker.sv
verif/testbench.sv
